// File: rtl/core/ptbg_pkg.sv
// ----------------------------------------------------------------------------
// ptbg_pkg: shared definitions for the burst-gated pulse train generator
// Register map, reset values and the configuration bundle that the top level
// hands to the timing core.
// ----------------------------------------------------------------------------
`default_nettype none

package ptbg_pkg;

  // Width of every configuration register as seen on the bus.
  localparam int unsigned REG_W = 32;

  // Default countdown width.
  localparam int unsigned TIME_WIDTH_DEF = 32;

  // Configuration bus address width: six registers at 4-byte spacing.
  localparam int unsigned CFG_AW = 5;

  // Register index field taken from the byte address.
  localparam int unsigned REG_IDX_W = 3;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_RUN_ENABLE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BURST_ENABLE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PULSE_ON     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PULSE_OFF    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BURST_ON     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BURST_OFF    = 3'd5;

  // Register reset values, in microseconds for the times.
  localparam logic [REG_W-1:0] PULSE_ON_RST  = 32'd1000;
  localparam logic [REG_W-1:0] PULSE_OFF_RST = 32'd49000;
  localparam logic [REG_W-1:0] BURST_ON_RST  = 32'd1000000;
  localparam logic [REG_W-1:0] BURST_OFF_RST = 32'd1000000;

  // Number of stream bus data bits on either side.
  localparam int unsigned TDATA_W = 8;

  // Configuration bundle from the register block to the timing core.
  typedef struct packed {
    logic             run_enable;
    logic             burst_enable;
    logic [REG_W-1:0] pulse_on_us;
    logic [REG_W-1:0] pulse_off_us;
    logic [REG_W-1:0] burst_on_us;
    logic [REG_W-1:0] burst_off_us;
  } cfg_t;

endpackage : ptbg_pkg

`default_nettype wire

// File: rtl/core/pulse_train_burst_generator.sv
// ----------------------------------------------------------------------------
// pulse_train_burst_generator: burst-gated pulse train generator
// Takes microsecond tick words and returns the output level and burst flag
// after each one; timing set through a small register port.
//
//   Channel | Direction | Handshake       | Word contents
//   in_     | input     | tvalid / tready | tdata[0] tick
//   out_    | output    | tvalid / tready | tdata[0] led_on, tdata[1] burst_active
//   cfg_    | input     | psel / penable  | six timing and enable registers
//
// A word is registered on entry and its result then in the result register;
// one word is taken every cycle while the result side drains.
// The countdowns update as a word moves from the entry register to the
// result register, which is the one stage that sets the rate.
// Reset is synchronous and active low and restores the register defaults.
// When out_tready is low the result holds and the entry stage fills, then
// in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_train_burst_generator #(
  parameter int unsigned TIME_WIDTH = ptbg_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input words
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [ptbg_pkg::TDATA_W-1:0]  in_tdata,   // [0] tick
  // Result words
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [ptbg_pkg::TDATA_W-1:0]       out_tdata,  // [0] led_on, [1] burst_active
  // Configuration port
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [ptbg_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [ptbg_pkg::REG_W-1:0]    cfg_pwdata,
  output logic [ptbg_pkg::REG_W-1:0]         cfg_prdata,
  output logic                               cfg_pready
);
  import ptbg_pkg::*;

  cfg_t                 cfg_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  logic                 s1_valid_r;
  logic                 s1_tick_r;
  logic                 out_valid_r;
  logic                 out_led_r;
  logic                 out_burst_r;
  logic                 advance;
  logic                 led_nxt;
  logic                 burst_nxt;

  // Register port: always ready, written in the access cycle.
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.run_enable   <= 1'b0;
      cfg_r.burst_enable <= 1'b0;
      cfg_r.pulse_on_us  <= PULSE_ON_RST;
      cfg_r.pulse_off_us <= PULSE_OFF_RST;
      cfg_r.burst_on_us  <= BURST_ON_RST;
      cfg_r.burst_off_us <= BURST_OFF_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_RUN_ENABLE:   cfg_r.run_enable   <= cfg_pwdata[0];
        REG_BURST_ENABLE: cfg_r.burst_enable <= cfg_pwdata[0];
        REG_PULSE_ON:     cfg_r.pulse_on_us  <= cfg_pwdata;
        REG_PULSE_OFF:    cfg_r.pulse_off_us <= cfg_pwdata;
        REG_BURST_ON:     cfg_r.burst_on_us  <= cfg_pwdata;
        REG_BURST_OFF:    cfg_r.burst_off_us <= cfg_pwdata;
        default: begin
        end
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      REG_RUN_ENABLE:   cfg_prdata = REG_W'(cfg_r.run_enable);
      REG_BURST_ENABLE: cfg_prdata = REG_W'(cfg_r.burst_enable);
      REG_PULSE_ON:     cfg_prdata = cfg_r.pulse_on_us;
      REG_PULSE_OFF:    cfg_prdata = cfg_r.pulse_off_us;
      REG_BURST_ON:     cfg_prdata = cfg_r.burst_on_us;
      REG_BURST_OFF:    cfg_prdata = cfg_r.burst_off_us;
      default:          cfg_prdata = '0;
    endcase
  end

  // Two-stage flow: entry register feeds the result register when it is
  // empty or being drained.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_tick_r <= in_tdata[0];
    end
    if (advance && s1_valid_r) begin
      out_led_r   <= led_nxt;
      out_burst_r <= burst_nxt;
    end
  end

  // Timing core: state commits as the word moves to the result register.
  ptbg_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .step      (advance && s1_valid_r),
    .tick      (s1_tick_r),
    .led_nxt   (led_nxt),
    .burst_nxt (burst_nxt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W-2){1'b0}}, out_burst_r, out_led_r};

endmodule : pulse_train_burst_generator

`default_nettype wire

// File: rtl/core/ptbg_core.sv
// ----------------------------------------------------------------------------
// ptbg_core: pulse and burst countdown state
// Holds the output level, burst flag and the two countdowns, and works out
// their next values for one tick word in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ptbg_core #(
  parameter int unsigned TIME_WIDTH = ptbg_pkg::TIME_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ptbg_pkg::cfg_t cfg,
  input  wire logic          step,       // commit the next state
  input  wire logic          tick,       // one microsecond has elapsed
  output logic               led_nxt,
  output logic               burst_nxt
);
  import ptbg_pkg::*;

  localparam int unsigned NRELOAD = 4;

  logic                  level_r,  level_nxt;
  logic                  in_burst_r, in_burst_nxt;
  logic [TIME_WIDTH-1:0] pulse_cnt_r, pulse_cnt_nxt;
  logic [TIME_WIDTH-1:0] burst_cnt_r, burst_cnt_nxt;

  logic [REG_W-1:0]      reload_raw [NRELOAD];
  logic [TIME_WIDTH-1:0] reload     [NRELOAD];

  logic [TIME_WIDTH-1:0] pulse_dec;
  logic [TIME_WIDTH-1:0] burst_dec;
  logic                  active;

  // Reload values clamped to the countdown width.
  assign reload_raw[0] = cfg.pulse_on_us;
  assign reload_raw[1] = cfg.pulse_off_us;
  assign reload_raw[2] = cfg.burst_on_us;
  assign reload_raw[3] = cfg.burst_off_us;

  for (genvar g = 0; g < NRELOAD; g++) begin : g_reload
    if (TIME_WIDTH >= REG_W) begin : g_wide
      assign reload[g] = TIME_WIDTH'(reload_raw[g]);
    end else begin : g_narrow
      assign reload[g] = (|reload_raw[g][REG_W-1:TIME_WIDTH]) ? '1
                                                               : reload_raw[g][TIME_WIDTH-1:0];
    end
  end

  // Saturating decrements.
  assign pulse_dec = (pulse_cnt_r == '0) ? '0 : pulse_cnt_r - TIME_WIDTH'(1);
  assign burst_dec = (burst_cnt_r == '0) ? '0 : burst_cnt_r - TIME_WIDTH'(1);
  assign active    = tick && cfg.run_enable;

  // Next state: the burst event takes priority and owns the pulse countdown.
  always_comb begin
    level_nxt     = level_r;
    in_burst_nxt  = in_burst_r;
    pulse_cnt_nxt = pulse_cnt_r;
    burst_cnt_nxt = burst_cnt_r;
    if (active) begin
      if (cfg.burst_enable && burst_dec == '0) begin
        if (in_burst_r) begin
          burst_cnt_nxt = reload[3];
          pulse_cnt_nxt = reload[3];
          level_nxt     = 1'b0;
          in_burst_nxt  = 1'b0;
        end else begin
          burst_cnt_nxt = reload[2];
          pulse_cnt_nxt = level_r ? reload[1] : reload[0];
          level_nxt     = !level_r;
          in_burst_nxt  = 1'b1;
        end
      end else begin
        if (cfg.burst_enable) begin
          burst_cnt_nxt = burst_dec;
        end
        if (pulse_dec == '0) begin
          pulse_cnt_nxt = level_r ? reload[1] : reload[0];
          level_nxt     = !level_r;
        end else begin
          pulse_cnt_nxt = pulse_dec;
        end
      end
    end
  end

  assign led_nxt   = level_nxt;
  assign burst_nxt = in_burst_nxt;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= 1'b0;
      in_burst_r  <= 1'b0;
      pulse_cnt_r <= '0;
      burst_cnt_r <= '0;
    end else if (step) begin
      level_r     <= level_nxt;
      in_burst_r  <= in_burst_nxt;
      pulse_cnt_r <= pulse_cnt_nxt;
      burst_cnt_r <= burst_cnt_nxt;
    end
  end

endmodule : ptbg_core

`default_nettype wire

// File: rtl/core/ptbg_checker.sv
// ----------------------------------------------------------------------------
// ptbg_checker: port-level checks for the pulse train generator
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptbg_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_tvalid,
  input wire logic                         in_tready,
  input wire logic [ptbg_pkg::TDATA_W-1:0] in_tdata,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [ptbg_pkg::TDATA_W-1:0] out_tdata
);
  import ptbg_pkg::*;

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Only the two result bits may be set.
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[TDATA_W-1:2] == '0)
    else $error("result padding bits not zero");

  // With the result side empty the block must take a new word.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty result register");

  // A word accepted with tdata[7] low yields a result if the sink stays ready.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tdata[7] && out_tready ##1 out_tready |=> out_tvalid)
    else $error("accepted word produced no result");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

endmodule : ptbg_checker

bind pulse_train_burst_generator ptbg_checker u_ptbg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
